>>> rtl/hbp_pkg.sv
// Shared types and constants for the Huffman bit packer.
// No dependencies; imported by every module of the block except hbp_ram.
`timescale 1ns / 1ps
`default_nettype none
package hbp_pkg;

	localparam int HBP_MAX_CODE_LEN = 32;
	localparam int SYM_W = 8;
	localparam int LEN_W = 6;
	localparam int CMD_W = 2;
	localparam int TBL_DEPTH = 256;
	localparam int IN_TDATA_W = 48;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	typedef struct packed {
		logic last;
		logic missing_code;
		logic byte_valid;
	} hbp_flags_t;

endpackage
`default_nettype wire

>>> rtl/hbp_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/hbp_table.sv
// Code table: code/length RAM plus per-entry valid bits so unwritten lengths read zero.
// Depends on hbp_pkg and hbp_ram.
`timescale 1ns / 1ps
`default_nettype none
module hbp_table import hbp_pkg::*; #(
	parameter int CODE_W = HBP_MAX_CODE_LEN
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic              rd_en,
	input  wire logic [SYM_W-1:0]  addr,
	input  wire logic [CODE_W-1:0] wr_code,
	input  wire logic [LEN_W-1:0]  wr_len,
	output logic      [CODE_W-1:0] rd_code,
	output logic      [LEN_W-1:0]  rd_len
);

	localparam int ENT_W = CODE_W + LEN_W;

	logic [TBL_DEPTH-1:0] vld_q;
	logic                 hit_q;
	logic [LEN_W-1:0]     len_sat;
	logic [ENT_W-1:0]     rd_ent;

	// saturate lengths beyond the store width
	assign len_sat = (wr_len > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : wr_len;

	hbp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TBL_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr),
		.wdata({len_sat, wr_code}),
		.re   (rd_en),
		.raddr(addr),
		.rdata(rd_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= vld_q[addr];
			end
		end
	end

	assign rd_code = rd_ent[CODE_W-1:0];
	assign rd_len  = hit_q ? rd_ent[ENT_W-1:CODE_W] : '0;

endmodule
`default_nettype wire

>>> rtl/hbp_pack.sv
// Bit packer: merges held bits with a code, splits off completed bytes, keeps the remainder.
// Depends on hbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hbp_pack import hbp_pkg::*; #(
	parameter int CODE_W = HBP_MAX_CODE_LEN
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 advance,
	input  wire logic [CMD_W-1:0]                     cmd,
	input  wire logic [CODE_W-1:0]                    code,
	input  wire logic [LEN_W-1:0]                     len,
	output logic      [8*((8+CODE_W+7)/8)-1:0]        res_data,
	output logic      [$clog2((8+CODE_W+7)/8+1)-1:0]  res_cnt,
	output hbp_flags_t                                res_flags
);

	localparam int TOT_W    = 8 + CODE_W;
	localparam int OB_BYTES = (TOT_W + 7) / 8;
	localparam int OB_W     = 8 * OB_BYTES;
	localparam int CNT_W    = $clog2(OB_BYTES + 1);
	localparam logic [6:0] OB_SH = 7'(OB_W);

	logic [7:0]       acc_q, acc_d;
	logic [2:0]       held_q, held_d;
	logic [TOT_W-1:0] merged;
	logic [6:0]       total;
	logic [OB_W-1:0]  aligned;
	logic [7:0]       padded;

	always_comb begin
		merged  = (TOT_W'(acc_q) << len) | (TOT_W'(code) & ~({TOT_W{1'b1}} << len));
		total   = 7'(held_q) + 7'(len);
		// earliest bit to the top of the result word
		aligned = OB_W'(merged) << (OB_SH - total);
		padded  = 8'(acc_q << (4'd8 - {1'b0, held_q}));

		res_data  = '0;
		res_cnt   = '0;
		res_flags = '0;
		acc_d     = acc_q;
		held_d    = held_q;

		case (cmd)
			CMD_ENC: begin
				res_cnt = CNT_W'(1);
				if (len == '0) begin
					res_flags.missing_code = 1'b1;
				end else begin
					res_data             = aligned;
					res_cnt              = CNT_W'(total[6:3]);
					res_flags.byte_valid = 1'b1;
					acc_d                = merged[7:0] & ~(8'hFF << total[2:0]);
					held_d               = total[2:0];
				end
			end
			CMD_FLUSH: begin
				res_cnt        = CNT_W'(1);
				res_flags.last = 1'b1;
				if (held_q != '0) begin
					res_data             = {padded, {(OB_W-8){1'b0}}};
					res_flags.byte_valid = 1'b1;
				end
				acc_d  = '0;
				held_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
		end else if (advance) begin
			acc_q  <= acc_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/huffman_bit_packer_core.sv
// Huffman bit packer, top level. Depends on hbp_pkg, hbp_table, hbp_pack, hbp_ram.
// A load is visible to an encode accepted in the next cycle; encode and flush results pass
// through the stage-one register (table read) and the output shift register. Throughput: one
// word per cycle in and out while the receiver keeps up; an item completing k bytes (k <= 4
// with 32-bit codes) holds the output shift register while the one-byte-per-cycle drain runs.
// Reset clears table valid bits, bit accumulator and pipeline; code RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module huffman_bit_packer_core import hbp_pkg::*; #(
	parameter int MAX_CODE_LEN = HBP_MAX_CODE_LEN
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// symbol[7:0], code_value[39:8], code_length[45:40], zero pad[47:46]
	input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
	// command[1:0]
	input  wire logic [CMD_W-1:0]      s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// packed_byte[7:0]
	output logic      [7:0]            m_axis_tdata,
	// byte_valid[0], missing_code[1]
	output logic      [1:0]            m_axis_tuser,
	output logic                       m_axis_tlast
);

	localparam int CODE_W   = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
	localparam int TOT_W    = 8 + CODE_W;
	localparam int OB_BYTES = (TOT_W + 7) / 8;
	localparam int OB_W     = 8 * OB_BYTES;
	localparam int CNT_W    = $clog2(OB_BYTES + 1);

	logic [CMD_W-1:0]  in_cmd;
	logic [SYM_W-1:0]  in_sym;
	logic [31:0]       in_code;
	logic [LEN_W-1:0]  in_len;
	logic              s_acc;
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic              s1_move;
	logic              ob_free;
	logic [CODE_W-1:0] tbl_code;
	logic [LEN_W-1:0]  tbl_len;
	logic [OB_W-1:0]   res_data;
	logic [CNT_W-1:0]  res_cnt;
	hbp_flags_t        res_flags;
	logic [OB_W-1:0]   ob_data_q;
	logic [CNT_W-1:0]  ob_cnt_q;
	hbp_flags_t        ob_flags_q;

	assign in_cmd  = s_axis_tuser;
	assign in_sym  = s_axis_tdata[7:0];
	assign in_code = s_axis_tdata[39:8];
	assign in_len  = s_axis_tdata[45:40];

	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign ob_free       = (ob_cnt_q == '0) || (ob_cnt_q == CNT_W'(1) && m_axis_tready);
	assign s1_move       = valid_s1 && ob_free;
	assign s_axis_tready = !valid_s1 || s1_move;

	hbp_table #(
		.CODE_W(CODE_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (s_acc && in_cmd == CMD_LOAD),
		.rd_en  (s_acc && in_cmd == CMD_ENC),
		.addr   (in_sym),
		.wr_code(in_code[CODE_W-1:0]),
		.wr_len (in_len),
		.rd_code(tbl_code),
		.rd_len (tbl_len)
	);

	hbp_pack #(
		.CODE_W(CODE_W)
	) u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (s1_move),
		.cmd      (cmd_s1),
		.code     (tbl_code),
		.len      (tbl_len),
		.res_data (res_data),
		.res_cnt  (res_cnt),
		.res_flags(res_flags)
	);

	// loads finish at the table; unused commands are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= (in_cmd == CMD_ENC) || (in_cmd == CMD_FLUSH);
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_s1 <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= '0;
		end else if (s1_move) begin
			ob_cnt_q <= res_cnt;
		end else if (m_axis_tvalid && m_axis_tready) begin
			ob_cnt_q <= ob_cnt_q - CNT_W'(1);
		end
	end

	// advance one byte per taken word
	always_ff @(posedge clk) begin
		if (s1_move) begin
			ob_data_q  <= res_data;
			ob_flags_q <= res_flags;
		end else if (m_axis_tvalid && m_axis_tready) begin
			ob_data_q <= ob_data_q << 8;
		end
	end

	assign m_axis_tvalid = (ob_cnt_q != '0);
	assign m_axis_tdata  = ob_data_q[OB_W-1 -: 8];
	assign m_axis_tuser  = {ob_flags_q.missing_code, ob_flags_q.byte_valid};
	assign m_axis_tlast  = ob_flags_q.last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q <= CNT_W'(OB_BYTES))
		else $error("output byte count beyond buffer size");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ob_free |-> !s_axis_tready)
		else $error("input taken while stage one is blocked");

	a_flush_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && cmd_s1 == CMD_FLUSH |=> m_axis_tvalid && m_axis_tlast)
		else $error("flush did not produce a last word");

	a_missing_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> ob_cnt_q == CNT_W'(1) && !m_axis_tuser[0])
		else $error("missing-code word malformed");

endmodule
`default_nettype wire

>>> test/hbp_stream_checker.sv
// Scoreboard for huffman_bit_packer_core: mirrors the code table and bit accumulator.
// Watches both stream channels; depends on hbp_pkg only.
`timescale 1ns / 1ps
module hbp_stream_checker import hbp_pkg::*; #(
	parameter int MAX_CODE_LEN = HBP_MAX_CODE_LEN
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic [CMD_W-1:0]      s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [7:0]            m_tdata,
	input  wire logic [1:0]            m_tuser,
	input  wire logic                  m_tlast,
	output int                         fail_count,
	output int                         pending,
	output int                         words_checked
);

	// code store is 32 bits wide, so longer codes clip there
	localparam int LEN_CAP = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       missing;
	} out_word_t;

	logic [31:0]      code_tab [TBL_DEPTH];
	logic [LEN_W-1:0] len_tab  [TBL_DEPTH];
	logic [7:0]       acc;
	logic [3:0]       held;
	out_word_t        expected_q [$];

	initial begin
		for (int i = 0; i < TBL_DEPTH; i++) begin
			len_tab[i] = '0;
		end
		acc = '0;
		held = '0;
		fail_count = 0;
		pending = 0;
		words_checked = 0;
	end

	// append one expected word at the tail
	task automatic queue_word(input out_word_t w);
		expected_q = {expected_q, w};
	endtask

	task automatic load_entry(input logic [7:0] sym, input logic [31:0] value,
			input logic [LEN_W-1:0] len);
		if (len > LEN_CAP)
			len = LEN_W'(LEN_CAP);
		code_tab[sym] = value;
		len_tab[sym] = len;
	endtask

	task automatic encode_symbol(input logic [7:0] sym);
		int        n;
		out_word_t w;
		n = len_tab[sym];
		if (n == 0) begin
			w = '{data: 8'h00, valid: 1'b0, last: 1'b0, missing: 1'b1};
			queue_word(w);
		end else begin
			// shift code bits in, most significant first
			for (int i = n; i > 0; i--) begin
				acc = {acc[6:0], code_tab[sym][i-1]};
				held++;
				if (held == 4'd8) begin
					w = '{data: acc, valid: 1'b1, last: 1'b0, missing: 1'b0};
					queue_word(w);
					acc = '0;
					held = '0;
				end
			end
		end
	endtask

	task automatic flush_bits();
		out_word_t w;
		if (held != 0)
			w = '{data: 8'(acc << (8 - held)), valid: 1'b1, last: 1'b1, missing: 1'b0};
		else
			w = '{data: 8'h00, valid: 1'b0, last: 1'b1, missing: 1'b0};
		queue_word(w);
		acc = '0;
		held = '0;
	endtask

	task automatic check_word();
		out_word_t want;
		words_checked++;
		if (expected_q.size() == 0) begin
			$error("unexpected output word: packed_byte %h user %b last %b",
				m_tdata, m_tuser, m_tlast);
			fail_count++;
		end else begin
			want = expected_q.pop_front();
			if (m_tdata !== want.data) begin
				$error("packed_byte: expected %h, got %h", want.data, m_tdata);
				fail_count++;
			end
			if (m_tuser[0] !== want.valid) begin
				$error("byte_valid: expected %b, got %b", want.valid, m_tuser[0]);
				fail_count++;
			end
			if (m_tuser[1] !== want.missing) begin
				$error("missing_code: expected %b, got %b", want.missing, m_tuser[1]);
				fail_count++;
			end
			if (m_tlast !== want.last) begin
				$error("last: expected %b, got %b", want.last, m_tlast);
				fail_count++;
			end
		end
	endtask

	// predict before comparing, so a same-edge result still finds its expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					CMD_LOAD:  load_entry(s_tdata[7:0], s_tdata[39:8], s_tdata[45:40]);
					CMD_ENC:   encode_symbol(s_tdata[7:0]);
					CMD_FLUSH: flush_bits();
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_word();
			pending = expected_q.size();
		end
	end

endmodule

>>> test/tb_huffman_bit_packer_core.sv
// Top of the bit packer testbench: clock, reset, word stimulus and verdict.
// Depends on hbp_pkg, huffman_bit_packer_core and hbp_stream_checker.
`timescale 1ns / 1ps
module tb_huffman_bit_packer_core;
	import hbp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int TARGET_ITEMS = 480;
	localparam int CALM_AFTER   = 420;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	int fail_count;
	int pending;
	int words_checked;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_go    = 1'b0;
	bit hold_done  = 1'b0;

	int n_items, n_load, n_enc, n_flush, n_ignored;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	huffman_bit_packer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	hbp_stream_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// abort if neither channel moves a word for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [7:0] sym,
			input logic [31:0] value, input logic [LEN_W-1:0] len);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, len, value, sym};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (cmd)
			CMD_LOAD:  n_load++;
			CMD_ENC:   n_enc++;
			CMD_FLUSH: n_flush++;
			default:   n_ignored++;
		endcase
		if (cmd != CMD_NONE)
			n_items++;
	endtask

	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 70)
			return LEN_W'($urandom_range(1, 12));
		else if (r < 90)
			return LEN_W'($urandom_range(13, 31));
		else if (r < 97)
			return LEN_W'(32);
		return LEN_W'($urandom_range(33, 63));
	endfunction

	// load a few entries, encode a run mostly over them, then flush
	task automatic run_message(input int n_loads, input int n_codes, input int min_len);
		logic [7:0]       syms [$];
		logic [7:0]       sym;
		logic [LEN_W-1:0] len;
		int               r;
		for (int i = 0; i < n_loads; i++) begin
			sym = 8'($urandom);
			len = (min_len > 0) ? LEN_W'($urandom_range(min_len, 32)) : pick_len();
			send_word(CMD_LOAD, sym, $urandom, len);
			syms = {syms, sym};
		end
		for (int i = 0; i < n_codes; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				send_word(CMD_NONE, 8'($urandom), $urandom, LEN_W'($urandom));
			else if (r < 7)
				send_word(CMD_FLUSH, 8'($urandom), $urandom, LEN_W'($urandom));
			else if (r < 14)
				send_word(CMD_ENC, 8'($urandom), $urandom, LEN_W'($urandom));
			else
				send_word(CMD_ENC, syms[$urandom_range(0, syms.size() - 1)], $urandom,
					LEN_W'($urandom));
		end
		send_word(CMD_FLUSH, 8'($urandom), $urandom, LEN_W'($urandom));
	endtask

	initial begin
		int msg_idx;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_LOAD;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, empty flush, length extremes, saturation, absent code
		send_word(CMD_ENC,   8'h00, 32'h0, 6'd0);
		send_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		send_word(CMD_LOAD,  8'h00, 32'h0000_0001, 6'd1);
		send_word(CMD_LOAD,  8'hFF, 32'hFFFF_FFFF, 6'd32);
		send_word(CMD_LOAD,  8'h41, 32'hFFFF_FFFA, 6'd3);
		send_word(CMD_LOAD,  8'h80, 32'h0000_00A5, 6'd8);
		send_word(CMD_LOAD,  8'h7F, 32'h1234_5678, 6'd40);
		send_word(CMD_LOAD,  8'h55, 32'h8000_0001, 6'd63);
		send_word(CMD_LOAD,  8'h10, 32'hDEAD_BEEF, 6'd0);
		send_word(CMD_ENC,   8'h80, 32'h0, 6'd0);
		send_word(CMD_ENC,   8'h00, 32'h0, 6'd0);
		send_word(CMD_ENC,   8'hFF, 32'h0, 6'd0);
		send_word(CMD_ENC,   8'h41, 32'h0, 6'd0);
		send_word(CMD_ENC,   8'h7F, 32'h0, 6'd0);
		send_word(CMD_ENC,   8'h10, 32'h0, 6'd0);
		send_word(CMD_ENC,   8'h55, 32'h0, 6'd0);
		send_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		send_word(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
		send_word(CMD_NONE,  8'hFF, 32'hFFFF_FFFF, 6'd63);
		send_word(CMD_ENC,   8'h00, 32'h0, 6'd0);
		send_word(CMD_ENC,   8'h41, 32'h0, 6'd0);
		send_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
		send_word(CMD_ENC,   8'h80, 32'h0, 6'd0);
		send_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0);

		msg_idx = 0;
		while (n_items < TARGET_ITEMS) begin
			tx_idle_on = (n_items < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (n_items < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			if (msg_idx == 3) begin
				// long codes against a stalled receiver back up the input
				hold_go = 1'b1;
				run_message(6, 40, 24);
			end else begin
				run_message($urandom_range(3, 12), $urandom_range(4, 30), 0);
			end
			msg_idx++;
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d words: %0d loads, %0d encodes, %0d flushes, %0d unused commands;",
			n_items + n_ignored, n_load, n_enc, n_flush, n_ignored);
		$display("checked %0d packed words over %0d messages.", words_checked, msg_idx);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
